// ----- hdl/sirs_pkg.sv -----
// ----------------------------------------------------------------------------
// sirs_pkg: shared types, constants and helpers
// Widths, register indexes, special bytes and the symbol lookup used by the
// signed integer to radix symbol converter.
// ----------------------------------------------------------------------------
package sirs_pkg;

    localparam int VALUE_W       = 32;
    localparam int SYM_W         = 8;
    localparam int DIGIT_W       = 4;
    localparam int LEN_W         = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int NUM_SYM_SLOTS = 16;
    localparam int ALPHA_W       = NUM_SYM_SLOTS * SYM_W;
    localparam int MAX_SYMBOLS_DEF = 16;

    // one cell per possible digit; radix 2 of 2^31 needs all of them
    localparam int NUM_CELLS = 32;
    localparam int CNT_W     = $clog2(2 * NUM_CELLS - 1);
    localparam int LEFT_W    = $clog2(NUM_CELLS + 1);

    localparam logic [CFG_IDX_W-1:0] REG_SYM_LO = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SYM_HI = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ALEN   = CFG_IDX_W'(2);

    localparam logic [SYM_W-1:0] MINUS_BYTE = 8'h2D;
    localparam logic [SYM_W-1:0] PLUS_BYTE  = 8'h2B;

    typedef struct packed {
        logic clr;    // clear digit and carry
        logic shift;  // move digit one cell up
    } t_cell_ctrl;

    function automatic logic [SYM_W-1:0] symbol_at(
        input logic [ALPHA_W-1:0] symbols,
        input logic [DIGIT_W-1:0] idx
    );
        return symbols[idx*SYM_W +: SYM_W];
    endfunction

endpackage

// ----- hdl/sirs_cell.sv -----
// ----------------------------------------------------------------------------
// sirs_cell: one radix digit cell
// Holds one digit and the carry it passes up; doubles the digit and adds the
// carry from the cell below, modulo the radix, or shifts a digit up.
// ----------------------------------------------------------------------------
module sirs_cell (
    input  logic                               i_clk,
    input  sirs_pkg::t_cell_ctrl               i_ctrl,
    input  logic                               i_step,
    input  logic [sirs_pkg::LEN_W-1:0]         i_radix,
    input  logic                               i_carry,
    input  logic [sirs_pkg::DIGIT_W-1:0]       i_shift_in,
    output logic [sirs_pkg::DIGIT_W-1:0]       o_digit,
    output logic                               o_carry
);

    logic [sirs_pkg::DIGIT_W-1:0] r_digit, n_digit;
    logic                         r_carry, n_carry;
    logic [sirs_pkg::LEN_W-1:0]   w_sum;
    logic [sirs_pkg::LEN_W-1:0]   w_mod;
    logic                         w_wrap;

    always_comb begin
        // 2*d + c, below twice the radix
        w_sum  = {r_digit, i_carry};
        w_wrap = (w_sum >= i_radix);
        w_mod  = w_wrap ? (w_sum - i_radix) : w_sum;
    end

    always_comb begin
        n_digit = r_digit;
        n_carry = r_carry;
        priority if (i_ctrl.clr) begin
            n_digit = '0;
            n_carry = 1'b0;
        end else if (i_ctrl.shift) begin
            n_digit = i_shift_in;
        end else if (i_step) begin
            n_digit = w_mod[sirs_pkg::DIGIT_W-1:0];
            n_carry = w_wrap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
        r_carry <= n_carry;
    end

    assign o_digit = r_digit;
    assign o_carry = r_carry;

endmodule

// ----- hdl/sirs_alpha_chk.sv -----
// ----------------------------------------------------------------------------
// sirs_alpha_chk: alphabet check sweep
// Walks the symbols one per cycle, flags sign bytes and repeats of earlier
// symbols; also checks the alphabet length against the bounds.
// ----------------------------------------------------------------------------
module sirs_alpha_chk #(
    parameter int MAX_SYMBOLS = sirs_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [sirs_pkg::ALPHA_W-1:0]       i_symbols,
    input  logic [sirs_pkg::LEN_W-1:0]         i_len,
    output logic                               o_ok
);

    localparam int IDX_W = $clog2(MAX_SYMBOLS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SYMBOLS - 1);

    logic             r_run, n_run;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_ok, n_ok;
    logic [sirs_pkg::SYM_W-1:0] w_sym;
    logic             w_bad;

    always_comb begin
        w_sym = sirs_pkg::symbol_at(i_symbols, sirs_pkg::DIGIT_W'(r_idx));
        w_bad = 1'b0;
        if (sirs_pkg::LEN_W'(r_idx) < i_len) begin
            if (w_sym == sirs_pkg::PLUS_BYTE || w_sym == sirs_pkg::MINUS_BYTE) begin
                w_bad = 1'b1;
            end
            for (int j = 0; j < MAX_SYMBOLS; j++) begin
                if (IDX_W'(j) < r_idx &&
                    sirs_pkg::symbol_at(i_symbols, sirs_pkg::DIGIT_W'(j)) == w_sym) begin
                    w_bad = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_run = r_run;
        n_idx = r_idx;
        n_ok  = r_ok;
        priority if (i_start) begin
            n_run = 1'b1;
            n_idx = '0;
            n_ok  = (i_len >= sirs_pkg::LEN_W'(2)) &&
                    (i_len <= sirs_pkg::LEN_W'(MAX_SYMBOLS));
        end else if (r_run) begin
            n_ok  = r_ok && !w_bad;
            n_idx = r_idx + IDX_W'(1);
            if (r_idx == IDX_LAST) begin
                n_run = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= n_run;
        end
        r_idx <= n_idx;
        r_ok  <= n_ok;
    end

    assign o_ok = r_ok;

endmodule

// ----- hdl/signed_int_to_radix_symbols_top.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_radix_symbols_top: signed integer to radix symbol text
// Converts a signed 32-bit number to its text in the radix of a configured
// symbol alphabet: optional '-' beat, then digit symbols most significant
// first with no leading zeros, last beat marked. Bad alphabet gives one
// error beat.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+--------------------------
//   in      | sink      | i_in_valid / o_in_stall    | i_value
//   out     | source    | o_out_valid / i_out_stall  | o_symbol o_last o_base_error
//   cfg     | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index i_cfg_data
//
// - conversion: magnitude bits enter a row of 32 radix cells one per cycle,
//   and carries move one cell per cycle
// - then leading-zero skip: one cell shift per leading zero, then a move
//   on to emission
// - then one beat per cycle for the sign and each digit, longer under stall
// - a bad alphabet gives its single error beat right after conversion
// - reset clears control and configuration state; the cells are cleared on each accept
// - one item at a time: o_in_stall is low only while idle
// ----------------------------------------------------------------------------
module signed_int_to_radix_symbols_top #(
    parameter int MAX_SYMBOLS = sirs_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input item
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [sirs_pkg::VALUE_W-1:0]    i_value,
    // result beats
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [sirs_pkg::SYM_W-1:0]             o_symbol,
    output logic                                   o_last,
    output logic                                   o_base_error,
    // configuration writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [sirs_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sirs_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int NC = sirs_pkg::NUM_CELLS;
    localparam logic [sirs_pkg::CNT_W-1:0]  CNT_END  = sirs_pkg::CNT_W'(2 * NC - 2);
    localparam logic [sirs_pkg::LEFT_W-1:0] LEFT_ONE = sirs_pkg::LEFT_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    // configuration registers
    logic [sirs_pkg::CFG_DATA_W-1:0] r_sym_lo, r_sym_hi;
    logic [sirs_pkg::LEN_W-1:0]      r_alen;

    // control
    t_state                        r_state, n_state;
    logic [sirs_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic [sirs_pkg::LEFT_W-1:0]   r_left, n_left;
    logic                          r_neg_pend, n_neg_pend;
    logic                          r_err, n_err;
    logic [sirs_pkg::VALUE_W-1:0]  r_mag, n_mag;

    // output register
    logic                          r_o_valid, n_o_valid;
    logic [sirs_pkg::SYM_W-1:0]    r_o_symbol, n_o_symbol;
    logic                          r_o_last, n_o_last;
    logic                          r_o_err, n_o_err;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_alpha_ok;
    logic [sirs_pkg::ALPHA_W-1:0]  w_alphabet;
    sirs_pkg::t_cell_ctrl          w_cell_ctrl;
    logic [NC-1:0]                 w_step;
    logic [NC-1:0]                 w_carry;
    logic [sirs_pkg::DIGIT_W-1:0]  w_digit [NC];
    logic [sirs_pkg::DIGIT_W-1:0]  w_top;

    assign w_alphabet = {r_sym_hi, r_sym_lo};
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_o_valid || !i_out_stall;
    assign w_top      = w_digit[NC-1];

    // config writes, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_lo <= '0;
            r_sym_hi <= '0;
            r_alen   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sirs_pkg::REG_SYM_LO: r_sym_lo <= i_cfg_data;
                sirs_pkg::REG_SYM_HI: r_sym_hi <= i_cfg_data;
                sirs_pkg::REG_ALEN:   r_alen   <= i_cfg_data[sirs_pkg::LEN_W-1:0];
                default: ;  // no register there
            endcase
        end
    end

    // alphabet check runs alongside the conversion
    sirs_alpha_chk #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_alpha_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_symbols (w_alphabet),
        .i_len     (r_alen),
        .o_ok      (w_alpha_ok)
    );

    // row of radix cells; cell g takes its last carry at count 31 + g
    genvar g;
    generate
        for (g = 0; g < NC; g++) begin : g_cell
            logic                         w_cin;
            logic [sirs_pkg::DIGIT_W-1:0] w_sin;

            if (g == 0) begin : g_first
                assign w_cin = r_mag[sirs_pkg::VALUE_W-1];
                assign w_sin = '0;
            end else begin : g_rest
                assign w_cin = w_carry[g-1];
                assign w_sin = w_digit[g-1];
            end

            assign w_step[g] = (r_state == ST_CONV) &&
                               (r_cnt <= sirs_pkg::CNT_W'(NC - 1 + g));

            sirs_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_cell_ctrl),
                .i_step     (w_step[g]),
                .i_radix    (r_alen),
                .i_carry    (w_cin),
                .i_shift_in (w_sin),
                .o_digit    (w_digit[g]),
                .o_carry    (w_carry[g])
            );
        end
    endgenerate

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_neg_pend  = r_neg_pend;
        n_err       = r_err;
        n_mag       = r_mag;
        n_o_valid   = r_o_valid;
        n_o_symbol  = r_o_symbol;
        n_o_last    = r_o_last;
        n_o_err     = r_o_err;
        w_cell_ctrl = '0;

        // downstream took the beat
        if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_cell_ctrl.clr = 1'b1;
                    n_neg_pend = i_value[sirs_pkg::VALUE_W-1];
                    n_mag      = i_value[sirs_pkg::VALUE_W-1] ?
                                 (sirs_pkg::VALUE_W'(0) - $unsigned(i_value)) :
                                 $unsigned(i_value);
                    n_cnt      = '0;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                // feed magnitude msb first into cell 0
                n_mag = {r_mag[sirs_pkg::VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + sirs_pkg::CNT_W'(1);
                if (r_cnt == CNT_END) begin
                    n_left  = sirs_pkg::LEFT_W'(NC);
                    n_err   = !w_alpha_ok;
                    n_state = w_alpha_ok ? ST_SKIP : ST_EMIT;
                end
            end
            ST_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (r_left != LEFT_ONE && w_top == '0) begin
                    w_cell_ctrl.shift = 1'b1;
                    n_left = r_left - LEFT_ONE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    priority if (r_err) begin
                        n_o_symbol = '0;
                        n_o_last   = 1'b1;
                        n_o_err    = 1'b1;
                        n_state    = ST_IDLE;
                    end else if (r_neg_pend) begin
                        n_o_symbol = sirs_pkg::MINUS_BYTE;
                        n_o_last   = 1'b0;
                        n_o_err    = 1'b0;
                        n_neg_pend = 1'b0;
                    end else begin
                        n_o_symbol = sirs_pkg::symbol_at(w_alphabet, w_top);
                        n_o_last   = (r_left == LEFT_ONE);
                        n_o_err    = 1'b0;
                        w_cell_ctrl.shift = 1'b1;
                        n_left     = r_left - LEFT_ONE;
                        if (r_left == LEFT_ONE) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
            r_cnt     <= '0;
            r_left    <= '0;
            r_err     <= 1'b0;
            r_neg_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_cnt     <= n_cnt;
            r_left    <= n_left;
            r_err     <= n_err;
            r_neg_pend <= n_neg_pend;
        end
        r_mag      <= n_mag;
        r_o_symbol <= n_o_symbol;
        r_o_last   <= n_o_last;
        r_o_err    <= n_o_err;
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_o_valid;
    assign o_symbol     = r_o_symbol;
    assign o_last       = r_o_last;
    assign o_base_error = r_o_err;

    // checks
    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_CONV) && (r_cnt == '0))
        else $error("accepted beat did not start conversion");

    a_conv_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV && r_cnt == CNT_END) |=> (r_state != ST_CONV))
        else $error("conversion ran past its last count");

    a_digits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SKIP) || (r_state == ST_EMIT && !r_err)) |-> (r_left != '0))
        else $error("digit emission with no digits left");

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_err) |-> (r_o_last && r_o_symbol == '0))
        else $error("error beat not last or not zero");

endmodule
